### rtl/fpba_pkg.sv
// fpba_pkg: shared types and constants of the fit-policy block allocator.
// No dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package fpba_pkg;

    // Fixed field widths of the request and result channels
    localparam int REQ_SIZE_W = 32;
    localparam int SLOT_W     = 6;
    localparam int LEFT_W     = 32;
    localparam int ST_W       = 2;
    localparam int POL_W      = 2;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = 1;

    // Search policy codes (code 3 behaves as first fit)
    typedef enum logic [POL_W-1:0] {
        POL_FIRST_FIT = 2'd0,
        POL_BEST_FIT  = 2'd1,
        POL_WORST_FIT = 2'd2
    } pol_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } st_t;

    // Request kinds
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // One classified request, as queued from front to back
    typedef struct packed {
        op_t                   op;
        logic [REQ_SIZE_W-1:0] size;
        logic [SLOT_W-1:0]     slot;
    } cmd_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } bk_state_t;

endpackage

### rtl/fpba_req_if.sv
// fpba_req_if: request channel (valid/ready plus request fields).
// Depends on fpba_pkg for field widths.
`timescale 1ns / 1ps

interface fpba_req_if;
    import fpba_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [REQ_SIZE_W-1:0] req_size;
    logic [SLOT_W-1:0]     free_slot;

    modport source (output valid, output req_type, output req_size, output free_slot,
                    input ready);
    modport sink   (input valid, input req_type, input req_size, input free_slot,
                    output ready);
endinterface

### rtl/fpba_rsp_if.sv
// fpba_rsp_if: result channel (valid/ready plus result fields).
// Depends on fpba_pkg for field widths.
`timescale 1ns / 1ps

interface fpba_rsp_if;
    import fpba_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] granted_slot;
    logic              reused;
    logic [LEFT_W-1:0] leftover_bytes;
    logic [ST_W-1:0]   status;

    modport source (output valid, output granted_slot, output reused,
                    output leftover_bytes, output status, input ready);
    modport sink   (input valid, input granted_slot, input reused,
                    input leftover_bytes, input status, output ready);
endinterface

### rtl/fpba_front.sv
// fpba_front: accepts request items, classifies them and pushes them to the queue.
// Depends on fpba_pkg and fpba_req_if.
`timescale 1ns / 1ps

module fpba_front (
    input  logic                clk,
    input  logic                rst_n,
    fpba_req_if.sink            req,
    input  fpba_pkg::q_stat_t   q_stat,
    output logic                push,
    output fpba_pkg::cmd_t      push_cmd
);
    import fpba_pkg::*;

    logic hold_vld_reg;
    logic hold_vld_next;
    cmd_t hold_cmd_reg;
    logic accept;

    assign push      = hold_vld_reg && !q_stat.full;
    assign req.ready = !hold_vld_reg || !q_stat.full;
    assign accept    = req.valid && req.ready;
    assign push_cmd  = hold_cmd_reg;

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        if (accept)
        begin
            hold_vld_next = 1'b1;
        end
        else if (push)
        begin
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg.op   <= req.req_type ? OP_FREE : OP_ALLOC;
            hold_cmd_reg.size <= req.req_size;
            hold_cmd_reg.slot <= req.free_slot;
        end
    end
endmodule

### rtl/fpba_queue.sv
// fpba_queue: short command queue that decouples front and back.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fpba_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output fpba_pkg::cmd_t      head,
    output fpba_pkg::q_stat_t   q_stat
);
    import fpba_pkg::*;

    cmd_t              ent_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign head         = ent_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == (QPTR_W+1)'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

### rtl/fpba_back.sv
// fpba_back: carries out queued commands against the block table and drives results.
// Depends on fpba_pkg and fpba_rsp_if; holds the size and free-mark memories.
`timescale 1ns / 1ps

module fpba_back #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fpba_pkg::POL_W-1:0]  fit_policy,
    input  fpba_pkg::cmd_t              head,
    input  fpba_pkg::q_stat_t           q_stat,
    output logic                        pop,
    fpba_rsp_if.source                  rsp
);
    import fpba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Table memories; entries below the entry count are always written first
    logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
    logic                 free_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic                 rd_free_reg;
    logic [IDX_W-1:0]     raddr;
    logic [IDX_W-1:0]     waddr;
    logic                 size_we;
    logic                 free_we;
    logic                 free_wdata;

    bk_state_t            state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     iss_reg, iss_next;
    logic                 evl_vld_reg, evl_vld_next;
    logic [IDX_W-1:0]     evl_idx_reg, evl_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic [SIZE_BITS-1:0] want_reg, want_next;

    logic                 out_vld_reg, out_vld_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic                 out_reused_reg, out_reused_next;
    logic [LEFT_W-1:0]    out_left_reg, out_left_next;
    st_t                  out_st_reg, out_st_next;
    logic                 out_load;

    logic                 fits;
    logic                 take;

    assign rsp.valid          = out_vld_reg;
    assign rsp.granted_slot   = out_slot_reg;
    assign rsp.reused         = out_reused_reg;
    assign rsp.leftover_bytes = out_left_reg;
    assign rsp.status         = out_st_reg;

    // Candidate test on the entry whose read data is now registered
    assign fits = evl_vld_reg && rd_free_reg && (rd_size_reg >= want_reg);
    assign take = fits && (!found_reg
                  || ((fit_policy == POL_BEST_FIT) && (rd_size_reg < pick_size_reg))
                  || ((fit_policy == POL_WORST_FIT) && (rd_size_reg > pick_size_reg)));

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        iss_next        = iss_reg;
        evl_vld_next    = evl_vld_reg;
        evl_idx_next    = evl_idx_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        want_next       = want_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_reused_next = out_reused_reg;
        out_left_next   = out_left_reg;
        out_st_next     = out_st_reg;
        out_load        = 1'b0;
        pop             = 1'b0;
        size_we         = 1'b0;
        free_we         = 1'b0;
        free_wdata      = 1'b0;
        waddr           = '0;
        raddr           = IDX_W'(iss_reg);

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && !out_vld_reg)
                begin
                    pop = 1'b1;
                    if (head.op == OP_FREE)
                    begin
                        out_load        = 1'b1;
                        out_slot_next   = head.slot;
                        out_reused_next = 1'b0;
                        out_left_next   = '0;
                        if (CMP_W'(head.slot) >= CMP_W'(cnt_reg))
                        begin
                            out_st_next = ST_BAD_FREE;
                        end
                        else
                        begin
                            free_we     = 1'b1;
                            free_wdata  = 1'b1;
                            waddr       = IDX_W'(head.slot);
                            out_st_next = ST_OK;
                        end
                    end
                    else
                    begin
                        want_next    = SIZE_BITS'(head.size);
                        found_next   = 1'b0;
                        iss_next     = '0;
                        evl_vld_next = 1'b0;
                        state_next   = BK_SCAN;
                    end
                end
            end
            BK_SCAN:
            begin
                // Issue one read per cycle, evaluate the one issued last cycle
                evl_vld_next = (iss_reg < cnt_reg);
                evl_idx_next = IDX_W'(iss_reg);
                if (iss_reg < cnt_reg)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_next      = evl_idx_reg;
                    pick_size_next = rd_size_reg;
                end
                if ((iss_reg >= cnt_reg) && !evl_vld_reg)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                out_load   = 1'b1;
                state_next = BK_IDLE;
                if (found_reg)
                begin
                    free_we         = 1'b1;
                    free_wdata      = 1'b0;
                    waddr           = pick_reg;
                    out_slot_next   = SLOT_W'(pick_reg);
                    out_reused_next = 1'b1;
                    out_left_next   = LEFT_W'(pick_size_reg - want_reg);
                    out_st_next     = ST_OK;
                end
                else if (cnt_reg == CNT_W'(MAX_BLOCKS))
                begin
                    out_slot_next   = '0;
                    out_reused_next = 1'b0;
                    out_left_next   = '0;
                    out_st_next     = ST_FULL;
                end
                else
                begin
                    // Append a new in-use entry of the requested size
                    size_we         = 1'b1;
                    free_we         = 1'b1;
                    free_wdata      = 1'b0;
                    waddr           = IDX_W'(cnt_reg);
                    cnt_next        = cnt_reg + CNT_W'(1);
                    out_slot_next   = SLOT_W'(cnt_reg);
                    out_reused_next = 1'b0;
                    out_left_next   = '0;
                    out_st_next     = ST_OK;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            iss_reg     <= '0;
            evl_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            iss_reg     <= iss_next;
            evl_vld_reg <= evl_vld_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evl_idx_reg    <= evl_idx_next;
        pick_reg       <= pick_next;
        pick_size_reg  <= pick_size_next;
        want_reg       <= want_next;
        out_slot_reg   <= out_slot_next;
        out_reused_reg <= out_reused_next;
        out_left_reg   <= out_left_next;
        out_st_reg     <= out_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[waddr] <= want_reg;
        end
        if (free_we)
        begin
            free_mem[waddr] <= free_wdata;
        end
        rd_size_reg <= size_mem[raddr];
        rd_free_reg <= free_mem[raddr];
    end
endmodule

### rtl/fit_policy_block_allocator.sv
// fit_policy_block_allocator: top level of the fit-policy block allocator.
// Depends on fpba_pkg, fpba_req_if, fpba_rsp_if, fpba_front, fpba_queue, fpba_back.
`timescale 1ns / 1ps

// Block allocator with a table of up to MAX_BLOCKS entries, each a recorded
// size and a free mark. An allocate item scans the table for a free entry
// that is large enough, picked by first, best or worst fit (set by
// cfg_wdata when cfg_we is high; write only while idle; code 3 is first
// fit; lowest index wins ties). With no fit a new in-use entry is appended,
// or status table-full is returned once the table holds MAX_BLOCKS entries.
// A free item marks the named entry free, or returns bad-free status for a
// slot at or above the entry count. Exactly one result item per request
// item, in order. The back end finishes one request before it takes the
// next; an allocate scans the table, reading one table entry per cycle
// from the single read port of the size memory. The front stage and a
// two-item queue keep accepting items, until both are full, while the
// back end scans or a result waits. Accepted requests pass through the
// front register and the queue before they enter the back end.
// No clearing pass after reset: entries above the entry count are never read.
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fpba_pkg::POL_W-1:0]  cfg_wdata,
    fpba_req_if.sink                    req,
    fpba_rsp_if.source                  rsp
);
    import fpba_pkg::*;

    // Policy register; the user must write it only while idle, the block does not enforce it
    logic [POL_W-1:0] fit_policy_reg;

    // Front-to-queue and queue-to-back links
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head;
    q_stat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= POL_FIRST_FIT;
        end
        else if (cfg_we)
        begin
            fit_policy_reg <= cfg_wdata;
        end
    end

    // Front: input item register and classification
    fpba_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Short queue so front and back stall independently
    fpba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // Back: table scan, decision, write-back and result register
    fpba_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fit_policy (fit_policy_reg),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .rsp        (rsp)
    );
endmodule

### rtl/fpba_checker.sv
// fpba_checker: port-level assertions on the allocator result channel.
// Depends on fpba_pkg; bound to fit_policy_block_allocator below.
`timescale 1ns / 1ps

module fpba_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [fpba_pkg::SLOT_W-1:0] granted_slot,
    input logic                        reused,
    input logic [fpba_pkg::LEFT_W-1:0] leftover_bytes,
    input logic [fpba_pkg::ST_W-1:0]   status
);
    import fpba_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(granted_slot) && $stable(reused)
            && $stable(leftover_bytes) && $stable(status))
        else $error("result payload changed while stalled");

    a_bad_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_BAD_FREE) |-> !reused && (leftover_bytes == '0))
        else $error("bad free result carries reuse or leftover");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL)
            |-> (granted_slot == '0) && !reused && (leftover_bytes == '0))
        else $error("table full result carries slot, reuse or leftover");

    a_new_entry_no_left: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_OK) && !reused |-> (leftover_bytes == '0))
        else $error("new entry or free result has nonzero leftover");
endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .granted_slot   (rsp.granted_slot),
    .reused         (rsp.reused),
    .leftover_bytes (rsp.leftover_bytes),
    .status         (rsp.status)
);
